// File: rtl/esc_pkg.sv
// Shared types, constants and register indexes of the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    // Disabled-channel codes of the raw readings
    localparam logic [23:0] RAW24_OFF = 24'h800000;
    localparam logic [15:0] RAW16_OFF = 16'h8000;

    // Humidity limits: signed Q9.22 before the final shift and unsigned Q7.10 after it
    localparam logic signed [31:0] HUM_RAW_MAX = 32'sd419430400;
    localparam logic [16:0]        HUM_OUT_MAX = 17'd102400;

    // Pipeline depths
    localparam int FRONT_STAGES = 11;
    localparam int DIV_STAGES   = 64;
    localparam int BACK_STAGES  = 6;

    // Register indexes on the configuration port (byte address / 8)
    localparam logic [2:0] REG_TEMP       = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_MID  = 3'd2;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd3;
    localparam logic [2:0] REG_HUM        = 3'd4;

    // Input word
    typedef struct packed {
        logic [23:0] raw_temp;
        logic [23:0] raw_press;
        logic [15:0] raw_hum;
    } sample_t;

    // Output word
    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic               temp_valid;
        logic signed [31:0] pressure_pa;
        logic               press_valid;
        logic [16:0]        humidity_q10;
        logic               hum_valid;
    } result_t;

    // Calibration coefficient registers
    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_low;
        logic [47:0] press_mid;
        logic [47:0] press_high;
        logic [63:0] hum;
    } coeff_t;

    // Finished fields that ride alongside the pressure division
    typedef struct packed {
        logic               qneg;
        logic               press_en;
        logic signed [15:0] temp_centi;
        logic               temp_valid;
        logic [16:0]        humidity_q10;
        logic               hum_valid;
    } side_t;

    // Divider operands: dividend and divisor magnitudes
    typedef struct packed {
        logic [63:0] ma;
        logic [30:0] mb;
        side_t       side;
    } div_in_t;

    // Divider result
    typedef struct packed {
        logic [63:0] quo;
        side_t       side;
    } div_out_t;

endpackage

`default_nettype wire

// File: rtl/esc_front.sv
// Front pipeline: temperature, humidity and pressure up to the division operands.
`timescale 1ns / 1ps
`default_nettype none

module esc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire esc_pkg::coeff_t coeffs,
    input  wire logic            in_valid,
    input  wire esc_pkg::sample_t in_data,
    output logic                 out_valid,
    output esc_pkg::div_in_t     out_data
);

    // Coefficient fields
    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6;
    logic        [7:0]  h1, h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;
    logic signed [63:0] p4w;
    logic signed [31:0] h4w;

    assign t1  = coeffs.temp[15:0];
    assign t2  = $signed(coeffs.temp[31:16]);
    assign t3  = $signed(coeffs.temp[47:32]);
    assign p1  = coeffs.press_low[15:0];
    assign p2  = $signed(coeffs.press_low[31:16]);
    assign p3  = $signed(coeffs.press_low[47:32]);
    assign p4  = $signed(coeffs.press_mid[15:0]);
    assign p5  = $signed(coeffs.press_mid[31:16]);
    assign p6  = $signed(coeffs.press_mid[47:32]);
    assign h1  = coeffs.hum[7:0];
    assign h2  = $signed(coeffs.hum[23:8]);
    assign h3  = coeffs.hum[31:24];
    assign h4  = $signed(coeffs.hum[43:32]);
    assign h5  = $signed(coeffs.hum[55:44]);
    assign h6  = $signed(coeffs.hum[63:56]);
    assign p4w = p4;
    assign h4w = h4;

    logic [esc_pkg::FRONT_STAGES-1:0] vld_reg;

    // Valid bits move with the words whenever the pipeline advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[esc_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    // Stage 1: temperature differences and first products
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [31:0] s1_pa_next, s1_psq_next;
    logic signed [31:0] s1_pa_reg, s1_psq_reg;
    logic [19:0] s1_adcp_reg;
    logic [15:0] s1_rh_reg;
    logic s1_tok_reg, s1_pok_reg, s1_hok_reg;

    always_comb
    begin
        d1 = $signed({1'b0, in_data.raw_temp[23:7]}) - $signed({1'b0, t1, 1'b0});
        d2 = $signed({1'b0, in_data.raw_temp[23:8]}) - $signed({1'b0, t1});
        s1_pa_next  = d1 * t2;
        s1_psq_next = d2 * d2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pa_reg   <= s1_pa_next;
            s1_psq_reg  <= s1_psq_next;
            s1_adcp_reg <= in_data.raw_press[23:4];
            s1_rh_reg   <= in_data.raw_hum;
            s1_tok_reg  <= (in_data.raw_temp != esc_pkg::RAW24_OFF);
            s1_pok_reg  <= (in_data.raw_press != esc_pkg::RAW24_OFF);
            s1_hok_reg  <= (in_data.raw_hum != esc_pkg::RAW16_OFF);
        end
    end

    // Stage 2: first temperature term and the squared term times T3
    logic signed [31:0] s2_x;
    logic signed [31:0] s2_va_next, s2_pb_next;
    logic signed [31:0] s2_va_reg, s2_pb_reg;
    logic [19:0] s2_adcp_reg;
    logic [15:0] s2_rh_reg;
    logic s2_tok_reg, s2_pok_reg, s2_hok_reg;

    always_comb
    begin
        s2_va_next = s1_pa_reg >>> 11;
        s2_x       = s1_psq_reg >>> 12;
        s2_pb_next = s2_x * t3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_va_reg   <= s2_va_next;
            s2_pb_reg   <= s2_pb_next;
            s2_adcp_reg <= s1_adcp_reg;
            s2_rh_reg   <= s1_rh_reg;
            s2_tok_reg  <= s1_tok_reg;
            s2_pok_reg  <= s1_pok_reg;
            s2_hok_reg  <= s1_hok_reg;
        end
    end

    // Stage 3: fine temperature
    logic signed [31:0] s3_pbs, s3_tf_next, s3_tf_reg;
    logic [19:0] s3_adcp_reg;
    logic [15:0] s3_rh_reg;
    logic s3_tok_reg, s3_pok_reg, s3_hok_reg;

    always_comb
    begin
        s3_pbs     = s2_pb_reg >>> 14;
        s3_tf_next = s2_va_reg + s3_pbs;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_tf_reg   <= s3_tf_next;
            s3_adcp_reg <= s2_adcp_reg;
            s3_rh_reg   <= s2_rh_reg;
            s3_tok_reg  <= s2_tok_reg;
            s3_pok_reg  <= s2_pok_reg;
            s3_hok_reg  <= s2_hok_reg;
        end
    end

    // Stage 4: temperature result; first pressure and humidity products
    logic signed [31:0] s4_t5, s4_tsh, s4_vh;
    logic signed [32:0] s4_v1;
    logic signed [15:0] s4_tc_next, s4_tc_reg;
    logic signed [63:0] s4_sq_next, s4_pm5_next, s4_pm2_next;
    logic signed [63:0] s4_sq_reg, s4_pm5_reg, s4_pm2_reg;
    logic signed [31:0] s4_m5h_next, s4_m6_next, s4_m3_next;
    logic signed [31:0] s4_m5h_reg, s4_m6_reg, s4_m3_reg;
    logic [19:0] s4_adcp_reg;
    logic [15:0] s4_rh_reg;
    logic s4_tok_reg, s4_pok_reg, s4_hok_reg;

    always_comb
    begin
        s4_t5  = (s3_tf_reg <<< 2) + s3_tf_reg + 32'sd128;
        s4_tsh = s4_t5 >>> 8;
        if (!s3_tok_reg)
        begin
            s4_tc_next = '0;
        end
        else if (s4_tsh > 32'sd32767)
        begin
            s4_tc_next = 16'sh7FFF;
        end
        else if (s4_tsh < -32'sd32768)
        begin
            s4_tc_next = 16'sh8000;
        end
        else
        begin
            s4_tc_next = s4_tsh[15:0];
        end
        s4_v1       = s3_tf_reg - 33'sd128000;
        s4_sq_next  = s4_v1 * s4_v1;
        s4_pm5_next = s4_v1 * p5;
        s4_pm2_next = s4_v1 * p2;
        s4_vh       = s3_tf_reg - 32'sd76800;
        s4_m5h_next = s4_vh * h5;
        s4_m6_next  = s4_vh * h6;
        s4_m3_next  = s4_vh * $signed({1'b0, h3});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_tc_reg   <= s4_tc_next;
            s4_sq_reg   <= s4_sq_next;
            s4_pm5_reg  <= s4_pm5_next;
            s4_pm2_reg  <= s4_pm2_next;
            s4_m5h_reg  <= s4_m5h_next;
            s4_m6_reg   <= s4_m6_next;
            s4_m3_reg   <= s4_m3_next;
            s4_adcp_reg <= s3_adcp_reg;
            s4_rh_reg   <= s3_rh_reg;
            s4_tok_reg  <= s3_tok_reg;
            s4_pok_reg  <= s3_pok_reg;
            s4_hok_reg  <= s3_hok_reg;
        end
    end

    // Stage 5: squared terms times P6 and P3; humidity a, c and d terms
    logic signed [31:0] s5_rh14, s5_ha;
    logic signed [63:0] s5_a6_next, s5_a3_next, s5_a6_reg, s5_a3_reg;
    logic signed [63:0] s5_pm5_reg, s5_pm2_reg;
    logic signed [31:0] s5_ah_next, s5_ch_next, s5_dh_next;
    logic signed [31:0] s5_ah_reg, s5_ch_reg, s5_dh_reg;
    logic signed [15:0] s5_tc_reg;
    logic [19:0] s5_adcp_reg;
    logic s5_tok_reg, s5_pok_reg, s5_hok_reg;

    always_comb
    begin
        s5_a6_next = s4_sq_reg * p6;
        s5_a3_next = s4_sq_reg * p3;
        s5_rh14    = $signed({2'b00, s4_rh_reg, 14'd0});
        s5_ha      = s5_rh14 - (h4w <<< 20) - s4_m5h_reg + 32'sd16384;
        s5_ah_next = s5_ha >>> 15;
        s5_ch_next = s4_m6_reg >>> 10;
        s5_dh_next = (s4_m3_reg >>> 11) + 32'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_a6_reg   <= s5_a6_next;
            s5_a3_reg   <= s5_a3_next;
            s5_pm5_reg  <= s4_pm5_reg;
            s5_pm2_reg  <= s4_pm2_reg;
            s5_ah_reg   <= s5_ah_next;
            s5_ch_reg   <= s5_ch_next;
            s5_dh_reg   <= s5_dh_next;
            s5_tc_reg   <= s4_tc_reg;
            s5_adcp_reg <= s4_adcp_reg;
            s5_tok_reg  <= s4_tok_reg;
            s5_pok_reg  <= s4_pok_reg;
            s5_hok_reg  <= s4_hok_reg;
        end
    end

    // Stage 6: pressure sums v2 and w; humidity c times d
    logic signed [63:0] s6_v2_next, s6_w_next, s6_v2_reg, s6_w_reg;
    logic signed [31:0] s6_cd_next, s6_cd_reg, s6_ah_reg;
    logic signed [15:0] s6_tc_reg;
    logic [19:0] s6_adcp_reg;
    logic s6_tok_reg, s6_pok_reg, s6_hok_reg;

    always_comb
    begin
        s6_v2_next = s5_a6_reg + (s5_pm5_reg <<< 17) + (p4w <<< 35);
        s6_w_next  = (s5_a3_reg >>> 8) + (s5_pm2_reg <<< 12);
        s6_cd_next = s5_ch_reg * s5_dh_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_v2_reg   <= s6_v2_next;
            s6_w_reg    <= s6_w_next;
            s6_cd_reg   <= s6_cd_next;
            s6_ah_reg   <= s5_ah_reg;
            s6_tc_reg   <= s5_tc_reg;
            s6_adcp_reg <= s5_adcp_reg;
            s6_tok_reg  <= s5_tok_reg;
            s6_pok_reg  <= s5_pok_reg;
            s6_hok_reg  <= s5_hok_reg;
        end
    end

    // Stage 7: divisor product with P1, dividend before scaling; humidity b times H2
    logic signed [63:0] s7_wp, s7_pp;
    logic signed [63:0] s7_y_next, s7_n0_next, s7_y_reg, s7_n0_reg;
    logic signed [31:0] s7_bh0, s7_bh_next, s7_bh_reg, s7_ah_reg;
    logic signed [15:0] s7_tc_reg;
    logic s7_tok_reg, s7_pok_reg, s7_hok_reg;

    always_comb
    begin
        s7_wp      = s6_w_reg + 64'sd140737488355328;
        s7_y_next  = s7_wp * $signed({1'b0, p1});
        s7_pp      = 64'sd1048576 - $signed({44'd0, s6_adcp_reg});
        s7_n0_next = (s7_pp <<< 31) - s6_v2_reg;
        s7_bh0     = (s6_cd_reg >>> 10) + 32'sd2097152;
        s7_bh_next = s7_bh0 * h2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_y_reg   <= s7_y_next;
            s7_n0_reg  <= s7_n0_next;
            s7_bh_reg  <= s7_bh_next;
            s7_ah_reg  <= s6_ah_reg;
            s7_tc_reg  <= s6_tc_reg;
            s7_tok_reg <= s6_tok_reg;
            s7_pok_reg <= s6_pok_reg;
            s7_hok_reg <= s6_hok_reg;
        end
    end

    // Stage 8: divisor, scaled dividend; humidity a times b
    logic signed [31:0] s8_b2;
    logic signed [63:0] s8_dv_next, s8_n_next, s8_dv_reg, s8_n_reg;
    logic signed [31:0] s8_ab_next, s8_ab_reg;
    logic signed [15:0] s8_tc_reg;
    logic s8_tok_reg, s8_pok_reg, s8_hok_reg;

    always_comb
    begin
        s8_dv_next = s7_y_reg >>> 33;
        s8_n_next  = s7_n0_reg * 64'sd3125;
        s8_b2      = (s7_bh_reg + 32'sd8192) >>> 14;
        s8_ab_next = s7_ah_reg * s8_b2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_dv_reg  <= s8_dv_next;
            s8_n_reg   <= s8_n_next;
            s8_ab_reg  <= s8_ab_next;
            s8_tc_reg  <= s7_tc_reg;
            s8_tok_reg <= s7_tok_reg;
            s8_pok_reg <= s7_pok_reg;
            s8_hok_reg <= s7_hok_reg;
        end
    end

    // Stage 9: operand magnitudes and signs; humidity square term
    logic [63:0] s9_dm;
    logic signed [31:0] s9_sh;
    logic [63:0] s9_ma_next, s9_ma_reg;
    logic [30:0] s9_mb_reg;
    logic s9_qneg_reg, s9_pen_next, s9_pen_reg, s9_hen_reg, s9_tok_reg;
    logic signed [31:0] s9_ss_next, s9_ss_reg, s9_ab_reg;
    logic signed [15:0] s9_tc_reg;

    always_comb
    begin
        s9_ma_next  = s8_n_reg[63] ? (64'd0 - s8_n_reg) : s8_n_reg;
        s9_dm       = s8_dv_reg[63] ? (64'd0 - s8_dv_reg) : s8_dv_reg;
        s9_pen_next = s8_tok_reg && s8_pok_reg && (s8_dv_reg != 64'sd0);
        s9_sh       = s8_ab_reg >>> 15;
        s9_ss_next  = s9_sh * s9_sh;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_ma_reg   <= s9_ma_next;
            s9_mb_reg   <= s9_dm[30:0];
            s9_qneg_reg <= s8_n_reg[63] ^ s8_dv_reg[63];
            s9_pen_reg  <= s9_pen_next;
            s9_hen_reg  <= s8_tok_reg && s8_hok_reg;
            s9_tok_reg  <= s8_tok_reg;
            s9_ss_reg   <= s9_ss_next;
            s9_ab_reg   <= s8_ab_reg;
            s9_tc_reg   <= s8_tc_reg;
        end
    end

    // Stage 10: humidity correction term times H1
    logic signed [31:0] s10_x_next, s10_x_reg, s10_ab_reg;
    logic [63:0] s10_ma_reg;
    logic [30:0] s10_mb_reg;
    logic s10_qneg_reg, s10_pen_reg, s10_hen_reg, s10_tok_reg;
    logic signed [15:0] s10_tc_reg;

    always_comb
    begin
        s10_x_next = (s9_ss_reg >>> 7) * $signed({1'b0, h1});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_x_reg    <= s10_x_next;
            s10_ab_reg   <= s9_ab_reg;
            s10_ma_reg   <= s9_ma_reg;
            s10_mb_reg   <= s9_mb_reg;
            s10_qneg_reg <= s9_qneg_reg;
            s10_pen_reg  <= s9_pen_reg;
            s10_hen_reg  <= s9_hen_reg;
            s10_tok_reg  <= s9_tok_reg;
            s10_tc_reg   <= s9_tc_reg;
        end
    end

    // Stage 11: humidity clamp and assembly of the divider word
    logic signed [31:0] s11_r;
    logic [16:0] s11_hum;
    esc_pkg::div_in_t s11_next, s11_reg;

    always_comb
    begin
        s11_r = s10_ab_reg - (s10_x_reg >>> 4);
        if (!s10_hen_reg || s11_r < 32'sd0)
        begin
            s11_hum = '0;
        end
        else if (s11_r > esc_pkg::HUM_RAW_MAX)
        begin
            s11_hum = esc_pkg::HUM_OUT_MAX;
        end
        else
        begin
            s11_hum = s11_r[28:12];
        end
        s11_next.ma                = s10_ma_reg;
        s11_next.mb                = s10_mb_reg;
        s11_next.side.qneg         = s10_qneg_reg;
        s11_next.side.press_en     = s10_pen_reg;
        s11_next.side.temp_centi   = s10_tc_reg;
        s11_next.side.temp_valid   = s10_tok_reg;
        s11_next.side.humidity_q10 = s11_hum;
        s11_next.side.hum_valid    = s10_hen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s11_reg <= s11_next;
        end
    end

    assign out_valid = vld_reg[esc_pkg::FRONT_STAGES-1];
    assign out_data  = s11_reg;

endmodule

`default_nettype wire

// File: rtl/esc_div.sv
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module esc_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire esc_pkg::div_in_t in_data,
    output logic                  out_valid,
    output esc_pkg::div_out_t     out_data
);

    localparam int N = esc_pkg::DIV_STAGES;

    logic [63:0]     dq_reg   [N];
    logic [30:0]     rem_reg  [N];
    logic [30:0]     mb_reg   [N];
    esc_pkg::side_t  side_reg [N];
    logic [63:0]     dq_next  [N];
    logic [30:0]     rem_next [N];
    logic [30:0]     mb_next  [N];
    esc_pkg::side_t  side_next [N];
    logic [N-1:0]    vld_reg;

    // Each stage shifts in the next dividend bit and subtracts the divisor when it fits
    always_comb
    begin
        logic [63:0] dq_in;
        logic [30:0] rem_in;
        logic [30:0] mb_in;
        logic [31:0] trial;
        logic        fits;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                dq_in        = in_data.ma;
                rem_in       = '0;
                mb_in        = in_data.mb;
                side_next[k] = in_data.side;
            end
            else
            begin
                dq_in        = dq_reg[k-1];
                rem_in       = rem_reg[k-1];
                mb_in        = mb_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            trial       = {rem_in, dq_in[63]};
            fits        = (trial >= {1'b0, mb_in});
            dq_next[k]  = {dq_in[62:0], fits};
            rem_next[k] = fits ? 31'(trial - {1'b0, mb_in}) : trial[30:0];
            mb_next[k]  = mb_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                dq_reg[k]   <= dq_next[k];
                rem_reg[k]  <= rem_next[k];
                mb_reg[k]   <= mb_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    // Valid bits follow the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    assign out_valid     = vld_reg[N-1];
    assign out_data.quo  = dq_reg[N-1];
    assign out_data.side = side_reg[N-1];

endmodule

`default_nettype wire

// File: rtl/esc_back.sv
// Back pipeline: quotient sign, P7 to P9 correction, saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none

module esc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire esc_pkg::coeff_t   coeffs,
    input  wire logic              in_valid,
    input  wire esc_pkg::div_out_t in_data,
    output logic                   out_valid,
    output esc_pkg::result_t       out_data
);

    logic signed [15:0] p7, p8, p9;
    logic signed [63:0] p7w;

    assign p7  = $signed(coeffs.press_high[15:0]);
    assign p8  = $signed(coeffs.press_high[31:16]);
    assign p9  = $signed(coeffs.press_high[47:32]);
    assign p7w = p7;

    logic [esc_pkg::BACK_STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[esc_pkg::BACK_STAGES-2:0], in_valid};
        end
    end

    // Stage 1: signed quotient
    logic signed [63:0] b1_q_next, b1_q_reg;
    esc_pkg::side_t b1_side_reg;

    always_comb
    begin
        b1_q_next = in_data.side.qneg ? (64'sd0 - $signed(in_data.quo)) : $signed(in_data.quo);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_q_reg    <= b1_q_next;
            b1_side_reg <= in_data.side;
        end
    end

    // Stage 2: P9 times the scaled quotient, P8 times the quotient
    logic signed [63:0] b2_ps_next, b2_t9_next, b2_w2_next;
    logic signed [63:0] b2_ps_reg, b2_t9_reg, b2_w2_reg, b2_q_reg;
    esc_pkg::side_t b2_side_reg;

    always_comb
    begin
        b2_ps_next = b1_q_reg >>> 13;
        b2_t9_next = b2_ps_next * p9;
        b2_w2_next = b1_q_reg * p8;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_ps_reg   <= b2_ps_next;
            b2_t9_reg   <= b2_t9_next;
            b2_w2_reg   <= b2_w2_next;
            b2_q_reg    <= b1_q_reg;
            b2_side_reg <= b1_side_reg;
        end
    end

    // Stage 3: 32-bit partial products of the wrapped 64-bit square term
    logic [63:0] b3_ll_next, b3_ll_reg;
    logic [31:0] b3_lh_next, b3_hl_next, b3_lh_reg, b3_hl_reg;
    logic signed [63:0] b3_w2_reg, b3_q_reg;
    esc_pkg::side_t b3_side_reg;

    always_comb
    begin
        b3_ll_next = 64'(b2_t9_reg[31:0]) * 64'(b2_ps_reg[31:0]);
        b3_lh_next = b2_t9_reg[31:0] * b2_ps_reg[63:32];
        b3_hl_next = b2_t9_reg[63:32] * b2_ps_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_ll_reg   <= b3_ll_next;
            b3_lh_reg   <= b3_lh_next;
            b3_hl_reg   <= b3_hl_next;
            b3_w2_reg   <= b2_w2_reg;
            b3_q_reg    <= b2_q_reg;
            b3_side_reg <= b2_side_reg;
        end
    end

    // Stage 4: combine the partial products
    logic [31:0] b4_mid;
    logic signed [63:0] b4_prod_next, b4_prod_reg, b4_w2_reg, b4_q_reg;
    esc_pkg::side_t b4_side_reg;

    always_comb
    begin
        b4_mid       = b3_lh_reg + b3_hl_reg;
        b4_prod_next = $signed(b3_ll_reg + {b4_mid, 32'd0});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b4_prod_reg <= b4_prod_next;
            b4_w2_reg   <= b3_w2_reg;
            b4_q_reg    <= b3_q_reg;
            b4_side_reg <= b3_side_reg;
        end
    end

    // Stage 5: corrected Q47.16 sum
    logic signed [63:0] b5_sum_next, b5_sum_reg;
    esc_pkg::side_t b5_side_reg;

    always_comb
    begin
        b5_sum_next = b4_q_reg + (b4_prod_reg >>> 25) + (b4_w2_reg >>> 19);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b5_sum_reg  <= b5_sum_next;
            b5_side_reg <= b4_side_reg;
        end
    end

    // Stage 6: add P7, drop the fraction, saturate and register the result word
    logic signed [63:0] b6_pr, b6_pv;
    logic signed [31:0] b6_pa;
    esc_pkg::result_t b6_next, b6_reg;

    always_comb
    begin
        b6_pr = (b5_sum_reg >>> 8) + (p7w <<< 4);
        b6_pv = b6_pr >>> 8;
        if (!b5_side_reg.press_en)
        begin
            b6_pa = '0;
        end
        else if (b6_pv > 64'sd2147483647)
        begin
            b6_pa = 32'sh7FFFFFFF;
        end
        else if (b6_pv < -64'sd2147483648)
        begin
            b6_pa = 32'sh80000000;
        end
        else
        begin
            b6_pa = b6_pv[31:0];
        end
        b6_next.temp_centi   = b5_side_reg.temp_centi;
        b6_next.temp_valid   = b5_side_reg.temp_valid;
        b6_next.pressure_pa  = b6_pa;
        b6_next.press_valid  = b5_side_reg.press_en;
        b6_next.humidity_q10 = b5_side_reg.humidity_q10;
        b6_next.hum_valid    = b5_side_reg.hum_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b6_reg <= b6_next;
        end
    end

    assign out_valid = vld_reg[esc_pkg::BACK_STAGES-1];
    assign out_data  = b6_reg;

endmodule

`default_nettype wire

// File: rtl/environmental_sensor_compensation.sv
// Top level: configuration registers, pipeline control and the three pipeline sections.
//
//  Channel  | Direction | Handshake                    | Word
//  ---------+-----------+------------------------------+---------------------------
//  sample   | in        | sample_valid / sample_ready  | esc_pkg::sample_t
//  result   | out       | result_valid / result_ready  | esc_pkg::result_t
//  config   | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata (64)
//
// One word is accepted per cycle while the output word is not held. There are 81
// register stages: the 11-stage front section, the 64-stage pressure divider (one
// quotient bit per stage) and the 6-stage back section. The first stage loads at the
// acceptance edge; the word passes through the stages in order to the output register.
// Reset clears the valid bits and the coefficient registers; no clearing pass is needed.
// When the output word is held, every stage holds together; bubbles keep moving
// whenever the output register is empty.
`timescale 1ns / 1ps
`default_nettype none

module environmental_sensor_compensation (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_ready,
    input  wire esc_pkg::sample_t sample,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output esc_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [5:0]       paddr,
    input  wire logic [63:0]      pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    esc_pkg::coeff_t coeff_reg;
    logic [2:0]      reg_idx;
    logic            adv;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    // Coefficient register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                esc_pkg::REG_TEMP:       coeff_reg.temp       <= pwdata[47:0];
                esc_pkg::REG_PRESS_LOW:  coeff_reg.press_low  <= pwdata[47:0];
                esc_pkg::REG_PRESS_MID:  coeff_reg.press_mid  <= pwdata[47:0];
                esc_pkg::REG_PRESS_HIGH: coeff_reg.press_high <= pwdata[47:0];
                esc_pkg::REG_HUM:        coeff_reg.hum        <= pwdata;
                default:                 ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            esc_pkg::REG_TEMP:       prdata = {16'd0, coeff_reg.temp};
            esc_pkg::REG_PRESS_LOW:  prdata = {16'd0, coeff_reg.press_low};
            esc_pkg::REG_PRESS_MID:  prdata = {16'd0, coeff_reg.press_mid};
            esc_pkg::REG_PRESS_HIGH: prdata = {16'd0, coeff_reg.press_high};
            esc_pkg::REG_HUM:        prdata = coeff_reg.hum;
            default:                 prdata = '0;
        endcase
    end

    // The whole pipeline moves unless a finished word waits at the output
    assign adv          = !result_valid || result_ready;
    assign sample_ready = adv;

    logic              front_valid;
    esc_pkg::div_in_t  front_data;
    logic              div_valid;
    esc_pkg::div_out_t div_data;

    esc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coeffs    (coeff_reg),
        .in_valid  (sample_valid),
        .in_data   (sample),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    esc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    esc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coeffs    (coeff_reg),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (result_valid),
        .out_data  (result)
    );

    // A disabled temperature channel forces every field of the word to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.temp_valid |->
            !result.press_valid && !result.hum_valid && result.temp_centi == 16'sd0 &&
            result.pressure_pa == 32'sd0 && result.humidity_q10 == 17'd0)
        else $error("temperature disabled but other fields are set");

    // Pressure reads zero whenever it is flagged invalid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.press_valid |-> result.pressure_pa == 32'sd0)
        else $error("invalid pressure is not zero");

    // Humidity never exceeds the clamp limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hum_valid |-> result.humidity_q10 <= esc_pkg::HUM_OUT_MAX)
        else $error("humidity above clamp limit");

    // With the output register empty, a word is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire
